### rtl/ceb_pkg.sv
`timescale 1ns / 1ps
package ceb_pkg;
   localparam int ValueWidth = 16;
   localparam int LossWidth  = 20;
   localparam int RowsWidth  = 17;
   localparam int SumWidth   = 37;
   localparam logic [LossWidth-1:0] LossMax = 20'hFFFFF;
   localparam logic [31:0] Ln2Q32 = 32'd2977044472;

   // One finished row handed from the front part to the back part.
   typedef struct packed {
      logic [ValueWidth-1:0] best_target;
      logic [ValueWidth-1:0] prediction;
      logic                  batch_end;
   } row_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOG, ST_SCALE, ST_LOSS, ST_DIV, ST_OUT
   } back_state_type;
endpackage

### rtl/ceb_stream_if.sv
`timescale 1ns / 1ps
interface ceb_stream_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/ceb_front.sv
`timescale 1ns / 1ps
// Tracks the first maximum of each row and pushes finished rows into a
// two-entry queue.
module ceb_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [ceb_pkg::ValueWidth-1:0]    target_value,
   input  logic [ceb_pkg::ValueWidth-1:0]    predicted_value,
   input  logic                              last_in_row,
   input  logic                              last_in_batch,
   output logic                              row_valid,
   input  logic                              row_ready,
   output ceb_pkg::row_type                  row_data
);
   logic [ceb_pkg::ValueWidth-1:0] best_ff, best_in, pred_ff, pred_in;
   logic started_ff, started_in;
   ceb_pkg::row_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic wr_ptr_ff, rd_ptr_ff;
   logic take, push, pop, upd;
   ceb_pkg::row_type new_row;

   assign in_ready  = (cnt_ff != 2'd2);
   assign take      = in_valid && in_ready;
   assign row_valid = (cnt_ff != 2'd0);
   assign row_data  = q_ff[rd_ptr_ff];
   assign pop       = row_valid && row_ready;
   assign push      = take && last_in_row;
   assign upd       = !started_ff || (target_value > best_ff);

   always_comb begin
      new_row.best_target = upd ? target_value : best_ff;
      new_row.prediction  = upd ? predicted_value : pred_ff;
      new_row.batch_end   = last_in_batch;
      best_in = best_ff;
      pred_in = pred_ff;
      started_in = started_ff;
      if (take) begin
         if (last_in_row) begin
            best_in = '0;
            pred_in = '0;
            started_in = 1'b0;
         end else begin
            best_in = new_row.best_target;
            pred_in = new_row.prediction;
            started_in = 1'b1;
         end
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
         pred_ff <= '0;
         started_ff <= 1'b0;
         cnt_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         best_ff <= best_in;
         pred_ff <= pred_in;
         started_ff <= started_in;
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= new_row;
   end
endmodule

### rtl/ceb_back.sv
`timescale 1ns / 1ps
// Computes the row loss with an iterative log2 and, at batch end, the mean
// with a restoring divider, one quotient bit per cycle.
module ceb_back #(
   parameter int MaxRows      = 65536,
   parameter int LogTableBits = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           row_valid,
   output logic                           row_ready,
   input  ceb_pkg::row_type               row_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [ceb_pkg::LossWidth-1:0]  row_loss,
   output logic [ceb_pkg::LossWidth-1:0]  mean_loss,
   output logic                           batch_done,
   output logic [ceb_pkg::RowsWidth-1:0]  rows_seen
);
   localparam int NW = 4 + LogTableBits;
   localparam int KW = $clog2(LogTableBits + 1);
   localparam int RW = $clog2(MaxRows + 1) + 1;
   localparam int SW = ceb_pkg::SumWidth;
   localparam int DW = $clog2(SW + 1);
   localparam int PW = NW + 32;

   ceb_pkg::back_state_type st_ff, st_in;
   ceb_pkg::row_type row_ff;
   logic [15:0] m_ff;
   logic [LogTableBits-1:0] f_ff;
   logic [3:0] sh_ff;
   logic [KW-1:0] k_ff;
   logic [ceb_pkg::LossWidth-1:0] neg_ln_ff;
   logic [SW-1:0] sum_ff;
   logic [RW-1:0] total_ff;
   logic [RW-1:0] dvs_ff;
   logic [SW-1:0] quo_ff, rem_ff;
   logic [DW-1:0] d_ff;
   logic [ceb_pkg::LossWidth-1:0] loss_ff, mean_ff;
   logic done_ff, sat_ff;
   logic [ceb_pkg::RowsWidth-1:0] seen_ff;

   logic [3:0] lead;
   logic [31:0] sq;
   logic [NW-1:0] n_full;
   logic [PW-1:0] prod;
   logic [35:0] lprod;
   logic [SW:0] trial;
   logic [ceb_pkg::LossWidth-1:0] loss_l;
   logic [SW-1:0] nsum;
   logic [RW-1:0] ntot;

   always_comb begin
      lead = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (row_data.prediction[i]) lead = 4'(i);
      end
   end

   assign sq     = 32'(m_ff) * 32'(m_ff);
   assign n_full = NW'({sh_ff, {LogTableBits{1'b0}}}) - NW'(f_ff);
   assign prod   = PW'(n_full) * PW'(ceb_pkg::Ln2Q32);
   assign lprod  = 36'(row_ff.best_target) * 36'(neg_ln_ff);
   assign trial  = {rem_ff, quo_ff[SW-1]} - (SW+1)'(dvs_ff);

   // Loss of the current row and the batch totals once it is counted.
   always_comb begin
      if (sat_ff || lprod[35]) loss_l = ceb_pkg::LossMax;
      else loss_l = lprod[34:15];
      nsum = sum_ff;
      ntot = total_ff;
      if (total_ff < RW'(MaxRows)) begin
         ntot = total_ff + 1'b1;
         nsum = sum_ff + SW'(loss_l);
      end
   end

   assign row_ready  = (st_ff == ceb_pkg::ST_IDLE);
   assign out_valid  = (st_ff == ceb_pkg::ST_OUT);
   assign row_loss   = loss_ff;
   assign mean_loss  = mean_ff;
   assign batch_done = done_ff;
   assign rows_seen  = seen_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ceb_pkg::ST_IDLE:  if (row_valid) st_in = ceb_pkg::ST_LOG;
         ceb_pkg::ST_LOG:   if (k_ff == KW'(LogTableBits)) st_in = ceb_pkg::ST_SCALE;
         ceb_pkg::ST_SCALE: st_in = ceb_pkg::ST_LOSS;
         ceb_pkg::ST_LOSS:  st_in = row_ff.batch_end ? ceb_pkg::ST_DIV : ceb_pkg::ST_OUT;
         ceb_pkg::ST_DIV:   if (d_ff == DW'(SW)) st_in = ceb_pkg::ST_OUT;
         ceb_pkg::ST_OUT:   if (out_ready) st_in = ceb_pkg::ST_IDLE;
         default:           st_in = ceb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ceb_pkg::ST_IDLE;
         sum_ff <= '0;
         total_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ceb_pkg::ST_LOSS) begin
            if (row_ff.batch_end) begin
               sum_ff <= '0;
               total_ff <= '0;
            end else begin
               sum_ff <= nsum;
               total_ff <= ntot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         ceb_pkg::ST_IDLE: begin
            row_ff <= row_data;
            m_ff <= row_data.prediction << (4'd15 - lead);
            sh_ff <= 4'd15 - lead;
            sat_ff <= (row_data.prediction == '0);
            f_ff <= '0;
            k_ff <= '0;
         end
         ceb_pkg::ST_LOG: begin
            if (k_ff != KW'(LogTableBits)) begin
               k_ff <= k_ff + 1'b1;
               if (sq[31]) begin
                  f_ff <= {f_ff[LogTableBits-2:0], 1'b1};
                  m_ff <= sq[31:16];
               end else begin
                  f_ff <= {f_ff[LogTableBits-2:0], 1'b0};
                  m_ff <= sq[30:15];
               end
            end
         end
         ceb_pkg::ST_SCALE: begin
            if ({sh_ff, {LogTableBits{1'b0}}} <= (NW)'(f_ff)) neg_ln_ff <= '0;
            else neg_ln_ff <= ceb_pkg::LossWidth'(prod >> (LogTableBits + 16));
         end
         ceb_pkg::ST_LOSS: begin
            loss_ff <= loss_l;
            seen_ff <= ceb_pkg::RowsWidth'(ntot);
            done_ff <= row_ff.batch_end;
            mean_ff <= '0;
            quo_ff <= nsum;
            rem_ff <= '0;
            d_ff <= '0;
            dvs_ff <= ntot;
         end
         ceb_pkg::ST_DIV: begin
            if (d_ff != DW'(SW)) begin
               d_ff <= d_ff + 1'b1;
               if (!trial[SW]) begin
                  rem_ff <= trial[SW-1:0];
                  quo_ff <= {quo_ff[SW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[SW-2:0], quo_ff[SW-1]};
                  quo_ff <= {quo_ff[SW-2:0], 1'b0};
               end
            end else begin
               mean_ff <= quo_ff[ceb_pkg::LossWidth-1:0];
            end
         end
         default: ;
      endcase
   end
endmodule

### rtl/cross_entropy_batch_loss.sv
`timescale 1ns / 1ps
// Elements are taken one per cycle while the two-row queue has room.
// A finished row goes through the back part's log2 iteration, scaling and loss
// steps, and a batch-end row then through the bit-serial divider as well.
// Synchronous active-high reset clears the row tracker, queue, sum and count.
module cross_entropy_batch_loss #(
   parameter int MAX_ROWS       = 65536,
   parameter int LOG_TABLE_BITS = 8
) (
   input logic clock,
   input logic reset,
   ceb_stream_if.sink   req,
   ceb_stream_if.source rsp
);
   logic row_valid, row_ready;
   ceb_pkg::row_type row_data;
   logic [ceb_pkg::LossWidth-1:0] row_loss, mean_loss;
   logic batch_done;
   logic [ceb_pkg::RowsWidth-1:0] rows_seen;

   ceb_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .target_value(req.payload[15:0]), .predicted_value(req.payload[31:16]),
      .last_in_row(req.payload[32]), .last_in_batch(req.payload[33]),
      .row_valid, .row_ready, .row_data
   );

   ceb_back #(.MaxRows(MAX_ROWS), .LogTableBits(LOG_TABLE_BITS)) u_back (
      .clock, .reset, .row_valid, .row_ready, .row_data,
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .row_loss, .mean_loss, .batch_done, .rows_seen
   );

   assign rsp.payload = {rows_seen, batch_done, mean_loss, row_loss};
endmodule
